// ----- sv/suffix_array_range_search_macros.svh -----
// Assertion macros used by the suffix array range search checker.
`ifndef SUFFIX_ARRAY_RANGE_SEARCH_MACROS_SVH
`define SUFFIX_ARRAY_RANGE_SEARCH_MACROS_SVH

// Check cons in the same cycle as ante, sampled on clk, off while in reset.
`define SARS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sars: check failed");

// Check cons in the cycle after ante, sampled on clk, off while in reset.
`define SARS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sars: check failed");

`endif

// ----- sv/sars_pkg.sv -----
// Shared types and constants for the suffix array range search block.
package sars_pkg;

  // Fixed field widths
  localparam int LEN_W    = 20;
  localparam int ROW_W    = LEN_W + 2;
  localparam int POS_W    = LEN_W + 1;
  localparam int KIND_W   = 2;
  localparam int SYM_IN_W = 3;

  // Parameter defaults
  localparam int REF_DEPTH_DEF   = 1048576;
  localparam int MAX_PATTERN_DEF = 1024;
  localparam int SYMBOL_BITS_DEF = 3;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_REF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PATTERN  = 2'd2;

  localparam logic [LEN_W-1:0] REF_LENGTH_RST = 20'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_ROW,
    ST_POS,
    ST_SYM,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_ref;
    logic load_sa;
    logic take;
    logic init_pass;
    logic calc_mid;
    logic row_rd;
    logic pos_rd;
    logic step_up;
    logic step_down;
    logic commit;
    logic ok;
    logic pass;
    logic nb;
  } sars_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic missed;
    logic empty;
    logic sym_lt;
    logic sym_gt;
    logic at_left;
    logic at_right;
    logic out_free;
  } sars_stat_t;

endpackage

// ----- sv/sars_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module sars_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/sars_ctrl.sv -----
// Controller state machine sequencing the two binary searches per pattern item.
module sars_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [sars_pkg::KIND_W-1:0]      in_kind,
  output logic                             in_ready,
  output sars_pkg::sars_cmd_t              cmd,
  input  sars_pkg::sars_stat_t             stat
);

  sars_pkg::state_t state_r, state_nxt;
  logic pass_r, pass_nxt;
  logic nb_r, nb_nxt;
  logic ok_r, ok_nxt;
  logic ready_c;
  logic found_c;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sars_pkg::ST_IDLE;
      pass_r  <= 1'b0;
      nb_r    <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      nb_r    <= nb_nxt;
      ok_r    <= ok_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    nb_nxt    = nb_r;
    ok_nxt    = ok_r;
    ready_c   = 1'b0;
    found_c   = 1'b0;
    cmd       = '0;
    cmd.pass  = pass_r;
    cmd.nb    = nb_r;
    cmd.ok    = ok_r;
    case (state_r)
      sars_pkg::ST_IDLE: begin
        ready_c = 1'b1;
        if (in_valid) begin
          case (in_kind)
            sars_pkg::KIND_LOAD_REF: cmd.load_ref = 1'b1;
            sars_pkg::KIND_LOAD_SA:  cmd.load_sa = 1'b1;
            sars_pkg::KIND_PATTERN: begin
              cmd.take  = 1'b1;
              state_nxt = sars_pkg::ST_START;
            end
            default: ;
          endcase
        end
      end
      sars_pkg::ST_START: begin
        if (stat.missed) begin
          ok_nxt    = 1'b0;
          state_nxt = sars_pkg::ST_FINISH;
        end else begin
          cmd.init_pass = 1'b1;
          cmd.pass      = 1'b0;
          pass_nxt      = 1'b0;
          nb_nxt        = 1'b0;
          state_nxt     = sars_pkg::ST_CHECK;
        end
      end
      sars_pkg::ST_CHECK: begin
        if (stat.empty) begin
          ok_nxt    = 1'b0;
          state_nxt = sars_pkg::ST_FINISH;
        end else begin
          cmd.calc_mid = 1'b1;
          nb_nxt       = 1'b0;
          state_nxt    = sars_pkg::ST_ROW;
        end
      end
      sars_pkg::ST_ROW: begin
        cmd.row_rd = 1'b1;
        state_nxt  = sars_pkg::ST_POS;
      end
      sars_pkg::ST_POS: begin
        cmd.pos_rd = 1'b1;
        state_nxt  = sars_pkg::ST_SYM;
      end
      sars_pkg::ST_SYM: begin
        if (!nb_r) begin
          // Probe at mid
          if (stat.sym_lt) begin
            cmd.step_up = 1'b1;
            state_nxt   = sars_pkg::ST_CHECK;
          end else if (stat.sym_gt) begin
            cmd.step_down = 1'b1;
            state_nxt     = sars_pkg::ST_CHECK;
          end else if (pass_r ? stat.at_right : stat.at_left) begin
            found_c = 1'b1;
          end else begin
            nb_nxt    = 1'b1;
            state_nxt = sars_pkg::ST_ROW;
          end
        end else begin
          // Neighbor probe: a different symbol marks the boundary
          nb_nxt = 1'b0;
          if (stat.sym_lt || stat.sym_gt) begin
            found_c = 1'b1;
          end else begin
            cmd.step_up   = pass_r;
            cmd.step_down = !pass_r;
            state_nxt     = sars_pkg::ST_CHECK;
          end
        end
        if (found_c) begin
          if (!pass_r) begin
            cmd.init_pass = 1'b1;
            cmd.pass      = 1'b1;
            pass_nxt      = 1'b1;
            state_nxt     = sars_pkg::ST_CHECK;
          end else begin
            ok_nxt    = 1'b1;
            state_nxt = sars_pkg::ST_FINISH;
          end
        end
      end
      sars_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = sars_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sars_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = ready_c;

endmodule

// ----- sv/sars_dp.sv -----
// Datapath: stores, search bounds, symbol fetch, pattern state and result register.
module sars_dp #(
  parameter int REF_DEPTH   = sars_pkg::REF_DEPTH_DEF,
  parameter int MAX_PATTERN = sars_pkg::MAX_PATTERN_DEF,
  parameter int SYMBOL_BITS = sars_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sars_pkg::LEN_W-1:0]    in_load_address,
  input  logic [sars_pkg::LEN_W-1:0]    in_load_value,
  input  logic [sars_pkg::SYM_IN_W-1:0] in_symbol,
  input  logic                          in_pattern_last,
  input  logic                          cfg_wr_en,
  input  logic [sars_pkg::LEN_W-1:0]    cfg_wr_data,
  input  sars_pkg::sars_cmd_t           cmd,
  output sars_pkg::sars_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sars_pkg::LEN_W-1:0]    out_lower_bound,
  output logic [sars_pkg::LEN_W-1:0]    out_upper_bound,
  output logic                          out_found,
  output logic                          out_is_last
);

  localparam int LEN_W     = sars_pkg::LEN_W;
  localparam int ROW_W     = sars_pkg::ROW_W;
  localparam int POS_W     = sars_pkg::POS_W;
  // Load addresses are 20 bits, so nothing past 2^20 can ever be written
  localparam int MEM_DEPTH = (REF_DEPTH < (1 << LEN_W)) ? REF_DEPTH : (1 << LEN_W);
  localparam int MA        = $clog2(MEM_DEPTH);
  localparam int OFF_W     = $clog2(MAX_PATTERN);

  logic [LEN_W-1:0]        ref_length_r;
  logic [LEN_W-1:0]        pl_r, pr_r, lb_r;
  logic [OFF_W-1:0]        off_r;
  logic                    missed_r;
  logic signed [ROW_W-1:0] low_r, high_r, mid_r;
  logic [SYMBOL_BITS-1:0]  c_r;
  logic                    last_r;
  logic                    row_oor_r, pos_oor_r;
  logic                    out_valid_r;
  logic [LEN_W-1:0]        out_lower_r, out_upper_r;
  logic                    out_found_r, out_last_r;

  logic signed [ROW_W:0]   mid_sum;
  logic signed [ROW_W-1:0] mid_calc, mid_inc, mid_dec, row_sel;
  logic                    row_oor, pos_oor, addr_ok;
  logic [POS_W-1:0]        pos;
  logic [LEN_W-1:0]        sa_rdata;
  logic [SYMBOL_BITS-1:0]  ref_rdata, sym_fetch;

  // Midpoint and neighbor rows
  assign mid_sum  = {low_r[ROW_W-1], low_r} + {high_r[ROW_W-1], high_r};
  assign mid_calc = mid_sum[ROW_W:1];
  assign mid_inc  = mid_r + ROW_W'(1);
  assign mid_dec  = mid_r - ROW_W'(1);
  assign row_sel  = cmd.nb ? (cmd.pass ? mid_inc : mid_dec) : mid_r;
  assign row_oor  = $unsigned(row_sel) >= ROW_W'(MEM_DEPTH);

  // Reference position of the probed suffix; past the end reads as terminator
  assign pos     = POS_W'(sa_rdata) + POS_W'(off_r);
  assign pos_oor = (pos >= POS_W'(ref_length_r)) || (pos >= POS_W'(MEM_DEPTH));
  assign sym_fetch = (row_oor_r || pos_oor_r) ? '0 : ref_rdata;
  assign addr_ok = POS_W'(in_load_address) < POS_W'(MEM_DEPTH);

  // Status to controller
  assign stat.missed   = missed_r;
  assign stat.empty    = low_r > high_r;
  assign stat.sym_lt   = sym_fetch < c_r;
  assign stat.sym_gt   = sym_fetch > c_r;
  assign stat.at_left  = mid_r == $signed({2'b00, pl_r});
  assign stat.at_right = mid_r == $signed({2'b00, pr_r});
  assign stat.out_free = !out_valid_r || out_ready;

  sars_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MEM_DEPTH)
  ) u_sa_ram (
    .clk   (clk),
    .we    (cmd.load_sa && addr_ok),
    .waddr (in_load_address[MA-1:0]),
    .wdata (in_load_value),
    .re    (cmd.row_rd),
    .raddr (row_sel[MA-1:0]),
    .rdata (sa_rdata)
  );

  sars_ram #(
    .WIDTH (SYMBOL_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (cmd.load_ref && addr_ok),
    .waddr (in_load_address[MA-1:0]),
    .wdata (in_load_value[SYMBOL_BITS-1:0]),
    .re    (cmd.pos_rd),
    .raddr (pos[MA-1:0]),
    .rdata (ref_rdata)
  );

  // Pattern state, interval, config and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_length_r <= sars_pkg::REF_LENGTH_RST;
      pl_r         <= '0;
      pr_r         <= '0;
      off_r        <= '0;
      missed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ref_length_r <= cfg_wr_data;
      end
      if (cmd.take && (off_r == '0)) begin
        pl_r     <= '0;
        pr_r     <= ref_length_r;
        missed_r <= 1'b0;
      end
      if (cmd.commit) begin
        if (cmd.ok) begin
          pl_r <= lb_r;
          pr_r <= mid_r[LEN_W-1:0];
        end
        if (last_r) begin
          off_r    <= '0;
          missed_r <= 1'b0;
        end else if (off_r < OFF_W'(MAX_PATTERN - 1)) begin
          off_r    <= off_r + 1'b1;
          missed_r <= missed_r || !cmd.ok;
        end else begin
          missed_r <= 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Search registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      c_r    <= SYMBOL_BITS'(in_symbol);
      last_r <= in_pattern_last;
    end
    if (cmd.init_pass) begin
      low_r  <= cmd.pass ? mid_r : $signed({2'b00, pl_r});
      high_r <= $signed({2'b00, pr_r});
      if (cmd.pass) begin
        lb_r <= mid_r[LEN_W-1:0];
      end
    end
    if (cmd.calc_mid) begin
      mid_r <= mid_calc;
    end
    if (cmd.step_up) begin
      low_r <= mid_inc;
    end
    if (cmd.step_down) begin
      high_r <= mid_dec;
    end
    if (cmd.row_rd) begin
      row_oor_r <= row_oor;
    end
    if (cmd.pos_rd) begin
      pos_oor_r <= pos_oor;
    end
    if (cmd.commit) begin
      out_lower_r <= cmd.ok ? lb_r : '0;
      out_upper_r <= cmd.ok ? mid_r[LEN_W-1:0] : '0;
      out_found_r <= cmd.ok;
      out_last_r  <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lower_bound = out_lower_r;
  assign out_upper_bound = out_upper_r;
  assign out_found       = out_found_r;
  assign out_is_last     = out_last_r;

endmodule

// ----- sv/suffix_array_range_search.sv -----
// Suffix array range search: narrows a suffix-array interval one pattern
// symbol at a time with two binary searches (leftmost and rightmost match).
// Load items (reference symbol or suffix array entry) are written from the
// idle state without leaving it. A pattern symbol passes accept, start and
// finish, plus per binary search probe a bound check, suffix array read,
// reference read and compare, a further suffix array read, reference read
// and compare per neighbor check on an equal probe, and one more bound check
// when a search runs empty; each of the two searches needs at most
// ceil(log2(ref_length + 2)) probes. Once a miss is latched a symbol passes
// only accept, start and finish. Each probe reads the suffix array and then
// the reference, a dependent pair of reads on one registered read port per
// store. A finished result waits in an output register while the next item
// is accepted; a stalled result holds the next pattern symbol in its finish
// state. Stores are not cleared by reset.
module suffix_array_range_search #(
  parameter int REF_DEPTH   = sars_pkg::REF_DEPTH_DEF,
  parameter int MAX_PATTERN = sars_pkg::MAX_PATTERN_DEF,
  parameter int SYMBOL_BITS = sars_pkg::SYMBOL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sars_pkg::LEN_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sars_pkg::KIND_W-1:0]   in_kind,
  input  logic [sars_pkg::LEN_W-1:0]    in_load_address,
  input  logic [sars_pkg::LEN_W-1:0]    in_load_value,
  input  logic [sars_pkg::SYM_IN_W-1:0] in_symbol,
  input  logic                          in_pattern_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sars_pkg::LEN_W-1:0]    out_lower_bound,
  output logic [sars_pkg::LEN_W-1:0]    out_upper_bound,
  output logic                          out_found,
  output logic                          out_is_last
);

  sars_pkg::sars_cmd_t  cmd;
  sars_pkg::sars_stat_t stat;

  sars_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sars_dp #(
    .REF_DEPTH   (REF_DEPTH),
    .MAX_PATTERN (MAX_PATTERN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_load_address (in_load_address),
    .in_load_value   (in_load_value),
    .in_symbol       (in_symbol),
    .in_pattern_last (in_pattern_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_lower_bound (out_lower_bound),
    .out_upper_bound (out_upper_bound),
    .out_found       (out_found),
    .out_is_last     (out_is_last)
  );

endmodule

// ----- sv/sars_checker.sv -----
// Port-level assertion checker for the suffix array range search, bound to the top.
`include "suffix_array_range_search_macros.svh"

module sars_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          cfg_wr_en,
  input logic [sars_pkg::LEN_W-1:0]    cfg_wr_data,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [sars_pkg::KIND_W-1:0]   in_kind,
  input logic [sars_pkg::LEN_W-1:0]    in_load_address,
  input logic [sars_pkg::LEN_W-1:0]    in_load_value,
  input logic [sars_pkg::SYM_IN_W-1:0] in_symbol,
  input logic                          in_pattern_last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sars_pkg::LEN_W-1:0]    out_lower_bound,
  input logic [sars_pkg::LEN_W-1:0]    out_upper_bound,
  input logic                          out_found,
  input logic                          out_is_last
);

  // A stalled result holds
  `SARS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_lower_bound) && $stable(out_upper_bound) && $stable(out_found) && $stable(out_is_last))

  // A miss reports an empty interval
  `SARS_ASSERT_NOW(a_miss_zero, out_valid && !out_found, (out_lower_bound == 0) && (out_upper_bound == 0))

  // A hit interval is ordered
  `SARS_ASSERT_NOW(a_hit_order, out_valid && out_found, out_lower_bound <= out_upper_bound)

  // A pattern item occupies the block: no item is taken in the next cycle
  `SARS_ASSERT_NEXT(a_busy_after_pattern, in_valid && in_ready && (in_kind == sars_pkg::KIND_PATTERN), !in_ready)

endmodule

bind suffix_array_range_search sars_checker u_sars_checker (.*);
